// ===== rtl/core/gcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// gcbf_pkg: shared constants and helpers for the great-circle bearing fold
// Fixed-point angle constants, CORDIC arctangent table and Q30 product.
// ----------------------------------------------------------------------------
package gcbf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // rotation datapath width and vectoring datapath width
  localparam int ROT_W = 34;
  localparam int VEC_W = 36;

  // degrees times 65536
  localparam logic signed [27:0] DEG360 = 28'sd23592960;
  localparam logic signed [27:0] DEG180 = 28'sd11796480;
  localparam logic signed [27:0] DEG90  = 28'sd5898240;

  // degrees to radians Q30, scaled by 2^32, split in two partial products
  localparam logic [40:0] DEG2RAD_K  = 41'd1228166276394;
  localparam int          D2R_LO_W   = 21;
  localparam logic [19:0] DEG2RAD_HI = 20'(DEG2RAD_K >> D2R_LO_W);
  localparam logic [20:0] DEG2RAD_LO = DEG2RAD_K[D2R_LO_W-1:0];

  // radians Q30 to degrees times 65536, scaled by 2^39
  localparam logic [30:0] RAD2DEG_K = 31'd1922527338;

  localparam logic signed [VEC_W-1:0] PI_Q30    = 36'sd3373259426;
  localparam logic signed [VEC_W-1:0] TWOPI_Q30 = 36'sd6746518852;
  localparam logic signed [ROT_W-1:0] GAIN_Q30  = 34'sd652032874;

  function automatic logic signed [VEC_W-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({{(VEC_W-32){1'b0}}, v});
  endfunction

  // Q30 product, rounded then floored
  function automatic logic signed [ROT_W-1:0] mulq(input logic signed [ROT_W-1:0] a,
                                                    input logic signed [ROT_W-1:0] b);
    logic signed [2*ROT_W-1:0] p;
    p = a * b + (2*ROT_W)'(64'sd536870912);
    return ROT_W'(p >>> 30);
  endfunction

endpackage

// ===== rtl/core/great_circle_bearing_fold.sv =====
// ----------------------------------------------------------------------------
// great_circle_bearing_fold: initial great-circle bearing and fold
// Accepts one transaction per cycle while the output is not stalled; the
// pipeline depth is set by the two unrolled CORDIC chains.
// Synchronous active-high reset clears the valid bits only; a stall on the
// output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module great_circle_bearing_fold #(
  parameter int CORDIC_STEPS = gcbf_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_latitude, first_longitude, second_latitude, second_longitude
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bearing, folded_angle
  output logic [55:0]  m_axis_tdata
);

  localparam int N   = CORDIC_STEPS;
  localparam int LAT = 2*N + 13;
  localparam int RW  = gcbf_pkg::ROT_W;
  localparam int VW  = gcbf_pkg::VEC_W;

  logic           en;
  logic [LAT-1:0] vld;

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // lanes: 0 first latitude, 1 second latitude, 2 longitude difference
  logic signed [27:0] ang_t  [3];
  logic signed [27:0] ang_w  [3];
  logic [22:0]        mag    [3];
  logic               nega3  [3];
  logic               negc3  [3];
  logic [43:0]        pp_lo  [3];
  logic [42:0]        pp_hi  [3];
  logic               nega4  [3];
  logic               negc4  [3];

  logic signed [RW-1:0] rx [3][0:N];
  logic signed [RW-1:0] ry [3][0:N];
  logic signed [RW-1:0] rz [3][0:N];
  logic                 rneg [3][0:N];

  logic signed [RW-1:0] sn [3];
  logic signed [RW-1:0] cs [3];

  // stage 1: capture, longitude difference, offset by two turns
  always_ff @(posedge clk) begin
    if (en) begin
      ang_t[0] <= 28'(28'($signed(s_axis_tdata[23:0])) + 2*gcbf_pkg::DEG360);
      ang_t[1] <= 28'(28'($signed(s_axis_tdata[72:49])) + 2*gcbf_pkg::DEG360);
      ang_t[2] <= 28'(28'($signed(s_axis_tdata[97:73])) - 28'($signed(s_axis_tdata[48:24]))
                  + 2*gcbf_pkg::DEG360);
    end
  end

  // stage 2: wrap into [-180, 180)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        logic [2:0] m;
        m = 3'(ang_t[l] >= gcbf_pkg::DEG180)
          + 3'(ang_t[l] >= gcbf_pkg::DEG180 + gcbf_pkg::DEG360)
          + 3'(ang_t[l] >= gcbf_pkg::DEG180 + 2*gcbf_pkg::DEG360)
          + 3'(ang_t[l] >= gcbf_pkg::DEG180 + 3*gcbf_pkg::DEG360);
        case (m)
          3'd0:    ang_w[l] <= ang_t[l];
          3'd1:    ang_w[l] <= ang_t[l] - gcbf_pkg::DEG360;
          3'd2:    ang_w[l] <= 28'(ang_t[l] - 2*gcbf_pkg::DEG360);
          3'd3:    ang_w[l] <= 28'(ang_t[l] - 3*gcbf_pkg::DEG360);
          default: ang_w[l] <= 28'(ang_t[l] - 4*gcbf_pkg::DEG360);
        endcase
      end
    end
  end

  // stage 3: mirror into [-90, 90], split sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        logic signed [27:0] a;
        if (ang_w[l] > gcbf_pkg::DEG90) begin
          a = gcbf_pkg::DEG180 - ang_w[l];
          negc3[l] <= 1'b1;
        end else if (ang_w[l] < -gcbf_pkg::DEG90) begin
          a = -gcbf_pkg::DEG180 - ang_w[l];
          negc3[l] <= 1'b1;
        end else begin
          a = ang_w[l];
          negc3[l] <= 1'b0;
        end
        nega3[l] <= a[27];
        mag[l]   <= a[27] ? 23'(-a) : 23'(a);
      end
    end
  end

  // stage 4: partial products of the radian conversion
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        pp_lo[l] <= 44'(mag[l]) * 44'(gcbf_pkg::DEG2RAD_LO);
        pp_hi[l] <= 43'(mag[l]) * 43'(gcbf_pkg::DEG2RAD_HI);
        nega4[l] <= nega3[l];
        negc4[l] <= negc3[l];
      end
    end
  end

  // stage 5: radians Q30, CORDIC seed
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        logic [63:0] sum;
        logic [RW-1:0] z;
        sum = {pp_hi[l], 21'd0} + 64'(pp_lo[l]) + 64'h8000_0000;
        z   = RW'(sum[63:32]);
        rz[l][0]   <= nega4[l] ? -$signed(z) : $signed(z);
        rx[l][0]   <= gcbf_pkg::GAIN_Q30;
        ry[l][0]   <= '0;
        rneg[l][0] <= negc4[l];
      end
    end
  end

  // rotation CORDIC, one iteration per stage
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (rz[l][i] >= 0) begin
            rx[l][i+1] <= rx[l][i] - (ry[l][i] >>> i);
            ry[l][i+1] <= ry[l][i] + (rx[l][i] >>> i);
            rz[l][i+1] <= rz[l][i] - RW'(gcbf_pkg::atan_q30(5'(i)));
          end else begin
            rx[l][i+1] <= rx[l][i] + (ry[l][i] >>> i);
            ry[l][i+1] <= ry[l][i] - (rx[l][i] >>> i);
            rz[l][i+1] <= rz[l][i] + RW'(gcbf_pkg::atan_q30(5'(i)));
          end
          rneg[l][i+1] <= rneg[l][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sn[l] <= ry[l][N];
        cs[l] <= rneg[l][N] ? -rx[l][N] : rx[l][N];
      end
    end
  end

  // spherical terms
  logic signed [RW-1:0] py1, pa1, pb1, cd1;
  logic signed [RW-1:0] py2, pa2, pc2;

  always_ff @(posedge clk) begin
    if (en) begin
      py1 <= gcbf_pkg::mulq(sn[2], cs[1]);
      pa1 <= gcbf_pkg::mulq(cs[0], sn[1]);
      pb1 <= gcbf_pkg::mulq(sn[0], cs[1]);
      cd1 <= cs[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      py2 <= py1;
      pa2 <= pa1;
      pc2 <= gcbf_pkg::mulq(pb1, cd1);
    end
  end

  // vectoring CORDIC
  logic signed [VW-1:0] vx [0:N];
  logic signed [VW-1:0] vy [0:N];
  logic signed [VW-1:0] vz [0:N];
  logic                 vzero [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [VW-1:0] xd, yd;
      xd = VW'(pa2) - VW'(pc2);
      yd = VW'(py2);
      vzero[0] <= (xd == '0) && (yd == '0);
      if (xd < 0) begin
        vx[0] <= -xd;
        vy[0] <= -yd;
        vz[0] <= gcbf_pkg::PI_Q30;
      end else begin
        vx[0] <= xd;
        vy[0] <= yd;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy[i] >= 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + gcbf_pkg::atan_q30(5'(i));
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - gcbf_pkg::atan_q30(5'(i));
        end
        vzero[i+1] <= vzero[i];
      end
    end
  end

  // angle into [0, 2pi), then to degrees
  logic [RW-1:0] rad;
  logic [64:0]   prod;
  logic [24:0]   deg;
  logic [24:0]   bearing;
  logic [23:0]   folded_angle;

  always_ff @(posedge clk) begin
    if (en) begin
      if (vzero[N]) begin
        rad <= '0;
      end else if (vz[N] < 0) begin
        rad <= RW'(vz[N] + gcbf_pkg::TWOPI_Q30);
      end else begin
        rad <= RW'(vz[N]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 65'(rad) * 65'(gcbf_pkg::RAD2DEG_K);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic [64:0] sum;
      logic [25:0] d;
      sum = prod + 65'h40_0000_0000;
      d   = 26'(sum >> 39);
      if (d >= 26'(gcbf_pkg::DEG360)) begin
        deg <= 25'(d - 26'(gcbf_pkg::DEG360));
      end else begin
        deg <= 25'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [25:0] f;
      f = 26'(gcbf_pkg::DEG180) - $signed({1'b0, deg});
      bearing      <= deg;
      folded_angle <= f[25] ? 24'(-f) : 24'(f);
    end
  end

  assign m_axis_tdata = {7'd0, folded_angle, bearing};

endmodule

// ===== verif/great_circle_bearing_fold_tb.sv =====
// ----------------------------------------------------------------------------
// great_circle_bearing_fold_tb: self-checking bench for the bearing fold
// Sends coordinate pairs, predicts bearing and fold with its own fixed-point
// CORDIC and compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module great_circle_bearing_fold_tb;

  localparam int          STEPS      = gcbf_pkg::CORDIC_STEPS_DEF;
  localparam int          N_RANDOM   = 1290;
  localparam int          LATENCY    = 2*STEPS + 13;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          STALL_AT   = 300;
  localparam int          STALL_LEN  = 400;
  localparam int          PAUSE_AT   = 800;
  localparam int          QUIET_LO   = 1000;
  localparam int          QUIET_HI   = 1200;
  localparam longint      K_DEG360   = 23592960;
  localparam longint      K_DEG180   = 11796480;
  localparam longint      K_DEG90    = 5898240;
  localparam longint      K_PI       = 64'd3373259426;
  localparam longint      K_TWOPI    = 64'd6746518852;
  localparam longint      K_GAIN     = 652032874;
  localparam longint unsigned K_D2R  = 64'd1228166276394;
  localparam longint unsigned K_R2D  = 64'd1922527338;

  typedef struct packed {
    logic [24:0] bearing;
    logic [23:0] folded;
  } heading_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;

  logic [103:0] pending_q[$];
  heading_t     heading_q[$];
  int           accepted = 0;
  int           mismatches = 0;
  int           cycles = 0;
  int           stall_left = 0;
  bit           stall_done = 0;
  bit           taken = 0;

  longint arc_tab[32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  great_circle_bearing_fold DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint q30_product(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic void sine_cosine(input longint ang, output longint sn,
                                      output longint cs);
    longint x, y, z, nx, a;
    longint unsigned mag;
    bit flip_cos, neg;
    a = (ang + 2 * K_DEG360) % K_DEG360;
    flip_cos = 0;
    if (a >= K_DEG180) a -= K_DEG360;
    if (a > K_DEG90) begin
      a = K_DEG180 - a;
      flip_cos = 1;
    end else if (a < -K_DEG90) begin
      a = -K_DEG180 - a;
      flip_cos = 1;
    end
    neg = a < 0;
    mag = neg ? -a : a;
    z = longint'((mag * K_D2R + 64'd2147483648) >> 32);
    if (neg) z = -z;
    x = K_GAIN;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arc_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arc_tab[i];
      end
      x = nx;
    end
    sn = y;
    cs = flip_cos ? -x : x;
  endfunction

  function automatic longint course_angle(longint y0, longint x0);
    longint x, y, z, nx;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = K_PI;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arc_tab[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arc_tab[i];
      end
      x = nx;
    end
    if (z < 0) z += K_TWOPI;
    return z;
  endfunction

  function automatic heading_t predict_heading(logic [103:0] d);
    longint lat1, lon1, lat2, lon2, s1, c1, s2, c2, sd, cd, y, x, r, deg, fold;
    heading_t h;
    lat1 = longint'($signed(d[23:0]));
    lon1 = longint'($signed(d[48:24]));
    lat2 = longint'($signed(d[72:49]));
    lon2 = longint'($signed(d[97:73]));
    sine_cosine(lat1, s1, c1);
    sine_cosine(lat2, s2, c2);
    sine_cosine(lon2 - lon1, sd, cd);
    y = q30_product(sd, c2);
    x = q30_product(c1, s2) - q30_product(q30_product(s1, c2), cd);
    r = course_angle(y, x);
    deg = longint'((longint'(r) * K_R2D + 64'd274877906944) >> 39);
    if (deg >= K_DEG360) deg -= K_DEG360;
    fold = K_DEG180 - deg;
    if (fold < 0) fold = -fold;
    h.bearing = deg[24:0];
    h.folded  = fold[23:0];
    return h;
  endfunction

  function automatic logic [103:0] pack_pair(logic [23:0] la1, logic [24:0] lo1,
                                             logic [23:0] la2, logic [24:0] lo2);
    return {6'd0, lo2, la2, lo1, la1};
  endfunction

  function automatic logic [23:0] rand_lat();
    if ($urandom_range(9) < 8) return 24'($signed($urandom_range(11796480)) - 5898240);
    return 24'($urandom);
  endfunction

  function automatic logic [24:0] rand_lon();
    if ($urandom_range(9) < 8) return 25'($signed($urandom_range(23592960)) - 11796480);
    return 25'($urandom);
  endfunction

  function automatic bit quiet_stretch();
    return accepted >= QUIET_LO && accepted < QUIET_HI;
  endfunction

  // stimulus and end of run
  initial begin
    // poles, antimeridian, coincident points (zero vector) and raw bit extremes
    pending_q.push_back(pack_pair(24'd0, 25'd0, 24'd0, 25'd0));
    pending_q.push_back(pack_pair(24'd0, 25'd0, 24'd5898240, 25'd0));
    pending_q.push_back(pack_pair(24'd0, 25'd0, -24'sd5898240, 25'd0));
    pending_q.push_back(pack_pair(24'd5898240, 25'd0, -24'sd5898240, 25'd11796480));
    pending_q.push_back(pack_pair(24'd0, -25'sd11796480, 24'd0, 25'd11796480));
    pending_q.push_back(pack_pair(24'd0, 25'd11796480, 24'd0, -25'sd11796480));
    pending_q.push_back(pack_pair(24'd0, 25'd0, 24'd0, 25'd11796480));
    pending_q.push_back(pack_pair(24'd0, 25'd0, 24'd0, 25'd5898240));
    pending_q.push_back(pack_pair(24'd0, 25'd0, 24'd0, -25'sd5898240));
    pending_q.push_back(pack_pair(24'd3276800, 25'd655360, 24'd3276800, 25'd655360));
    pending_q.push_back(pack_pair(24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000));
    pending_q.push_back(pack_pair(24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF));
    pending_q.push_back(pack_pair(24'hFFFFFF, 25'h1FFFFFF, 24'hFFFFFF, 25'h1FFFFFF));
    pending_q.push_back(pack_pair(24'h555555, 25'h0AAAAAA, 24'hAAAAAA, 25'h1555555));
    pending_q.push_back(pack_pair(-24'sd5898240, -25'sd11796480, 24'd5898240, 25'd11796480));
    pending_q.push_back(pack_pair(24'd65536, 25'd0, 24'd0, 25'd1));
    for (int i = 0; i < N_RANDOM; i++)
      pending_q.push_back(pack_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon()));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && !s_axis_tvalid && heading_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // record accepted input transactions
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      heading_q.push_back(predict_heading(s_axis_tdata));
      accepted <= accepted + 1;
      taken <= 1'b1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst && (taken || !s_axis_tvalid)) begin
      taken <= 1'b0;
      if (pending_q.size() != 0 && !(accepted == PAUSE_AT && heading_q.size() != 0)
          && (quiet_stretch() || $urandom_range(99) >= 9)) begin
        s_axis_tdata  <= pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off to back the pipeline up
  always @(negedge clk) begin
    if (!stall_done && accepted >= STALL_AT) begin
      stall_done <= 1'b1;
      stall_left <= STALL_LEN;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_stretch() || $urandom_range(99) >= 9;
    end
  end

  // monitor
  always @(posedge clk) begin
    heading_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.bearing = m_axis_tdata[24:0];
      got.folded  = m_axis_tdata[48:25];
      if (heading_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %h", m_axis_tdata);
      end else begin
        want = heading_q.pop_front();
        if (got.bearing !== want.bearing || got.folded !== want.folded) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: bearing exp %0d got %0d, fold exp %0d got %0d",
                     want.bearing, got.bearing, want.folded, got.folded);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/gcbf_pkg.sv
rtl/core/great_circle_bearing_fold.sv
verif/great_circle_bearing_fold_tb.sv
